FILE: hw/rtl/tk_pkg.sv
`timescale 1ns / 1ps

package tk_pkg;

    localparam int KEY_W     = 32;
    localparam int OUT_TAG_W = 16;
    localparam int IDX_IN_W  = 4;
    localparam int CAP_W     = 5;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_READ   = 1'b1
    } action_t;

    localparam logic REG_CAPACITY = 1'b0;

    // Broadcast from the top level to every cell for one insert.
    typedef struct packed {
        logic                    insert;
        logic                    full;
        logic signed [KEY_W-1:0] key;
    } tk_ctrl_t;

endpackage

FILE: hw/rtl/tk_cell.sv
`timescale 1ns / 1ps

module tk_cell #(
    parameter int TAG_BITS = 16,
    parameter int CNT_W    = 5,
    parameter int INDEX    = 0
) (
    input  logic                            aclk,
    input  tk_pkg::tk_ctrl_t                ctrl,
    input  logic [TAG_BITS-1:0]             new_tag,
    input  logic [CNT_W-1:0]                count,
    input  logic signed [tk_pkg::KEY_W-1:0] prev_key,
    input  logic [TAG_BITS-1:0]             prev_tag,
    input  logic                            prev_less,
    input  logic signed [tk_pkg::KEY_W-1:0] next_key,
    input  logic [TAG_BITS-1:0]             next_tag,
    input  logic                            next_less,
    output logic signed [tk_pkg::KEY_W-1:0] key,
    output logic [TAG_BITS-1:0]             tag,
    output logic                            less,
    output logic signed [tk_pkg::KEY_W-1:0] key_next
);
    import tk_pkg::*;

    logic signed [KEY_W-1:0] key_reg;
    logic [TAG_BITS-1:0]     tag_reg;
    logic [TAG_BITS-1:0]     tag_next;
    logic                    occupied;

    assign occupied = count > CNT_W'(INDEX);
    assign less     = occupied && (key_reg < ctrl.key);
    assign key      = key_reg;
    assign tag      = tag_reg;

    // Not full: entries at or past the insert point move up one cell.
    // Full: entries below the insert point move down, dropping the minimum.
    always_comb begin
        key_next = key_reg;
        tag_next = tag_reg;
        if (!ctrl.full) begin
            if (!less) begin
                if (prev_less) begin
                    key_next = ctrl.key;
                    tag_next = new_tag;
                end else begin
                    key_next = prev_key;
                    tag_next = prev_tag;
                end
            end
        end else if (less) begin
            if (next_less) begin
                key_next = next_key;
                tag_next = next_tag;
            end else begin
                key_next = ctrl.key;
                tag_next = new_tag;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.insert) begin
            key_reg <= key_next;
            tag_reg <= tag_next;
        end
    end

endmodule

FILE: hw/rtl/top_k_sorted_keeper.sv
`timescale 1ns / 1ps

// Sorted top-K keeper built as a row of MAX_ENTRIES compare-and-shift cells.
// Entries are held in ascending key order; one transfer is taken per cycle,
// insert or read, and its result appears in the output register on the next
// cycle. Every cell compares its key against the incoming key in parallel and
// moves one step toward or from its neighbor, so every cell updates at once,
// whatever the insert position. A waiting result does not block the
// next transfer while m_ready is high. The capacity register (byte address 0)
// sets how many entries are kept; when full, the smallest is dropped and an
// insert not above the minimum is refused (accepted = 0).
module top_k_sorted_keeper #(
    parameter int MAX_ENTRIES = 16,
    parameter int TAG_BITS    = 16,
    localparam int CNT_W      = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tk_pkg::APB_AW-1:0]         paddr,
    input  logic [tk_pkg::APB_DW-1:0]         pwdata,
    output logic [tk_pkg::APB_DW-1:0]         prdata,
    output logic                              pready,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_action,
    input  logic signed [tk_pkg::KEY_W-1:0]   s_fitness_key,
    input  logic [tk_pkg::OUT_TAG_W-1:0]      s_entry_tag,
    input  logic [tk_pkg::IDX_IN_W-1:0]       s_read_index,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [tk_pkg::KEY_W-1:0]   m_read_key,
    output logic [tk_pkg::OUT_TAG_W-1:0]      m_read_tag,
    output logic                              m_read_valid,
    output logic                              m_accepted,
    output logic signed [tk_pkg::KEY_W-1:0]   m_minimum_key,
    output logic [CNT_W-1:0]                  m_occupancy
);
    import tk_pkg::*;

    localparam int CW = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int IW = (CNT_W > IDX_IN_W) ? CNT_W : IDX_IN_W;
    localparam int TW = (TAG_BITS > OUT_TAG_W) ? TAG_BITS : OUT_TAG_W;

    logic [CAP_W-1:0]        capacity_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [CNT_W-1:0]        eff_cap;
    logic [CW-1:0]           cap_wide;
    logic                    cfg_wr;
    logic                    fire;
    logic                    is_read;
    tk_ctrl_t                ctrl;
    logic [TW-1:0]           tag_wide_in;
    logic [TAG_BITS-1:0]     tag_in;

    logic signed [KEY_W-1:0] cell_key      [MAX_ENTRIES];
    logic [TAG_BITS-1:0]     cell_tag      [MAX_ENTRIES];
    logic signed [KEY_W-1:0] cell_key_next [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]  cell_less;

    logic signed [KEY_W-1:0] rd_key;
    logic [TAG_BITS-1:0]     rd_tag;
    logic [TW-1:0]           rd_tag_wide;
    logic                    rd_valid;

    logic                    m_valid_reg;
    logic signed [KEY_W-1:0] read_key_reg;
    logic [OUT_TAG_W-1:0]    read_tag_reg;
    logic                    read_valid_reg;
    logic                    accepted_reg;
    logic signed [KEY_W-1:0] minimum_key_reg;
    logic [CNT_W-1:0]        occupancy_reg;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DW'(capacity_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
        end else if (cfg_wr && paddr[2] == REG_CAPACITY) begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    // Capacity zero counts as one, anything above the row length saturates.
    assign cap_wide = CW'(capacity_reg);
    always_comb begin
        if (cap_wide == '0) begin
            eff_cap = CNT_W'(1);
        end else if (cap_wide > CW'(MAX_ENTRIES)) begin
            eff_cap = CNT_W'(MAX_ENTRIES);
        end else begin
            eff_cap = cap_wide[CNT_W-1:0];
        end
    end

    assign s_ready = !m_valid_reg || m_ready;
    assign fire    = s_valid && s_ready;
    assign is_read = (s_action == ACT_READ);

    assign tag_wide_in = TW'(s_entry_tag);
    assign tag_in      = tag_wide_in[TAG_BITS-1:0];

    assign ctrl.insert = fire && !is_read;
    assign ctrl.full   = (count_reg >= eff_cap);
    assign ctrl.key    = s_fitness_key;

    // Cell row
    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
        logic signed [KEY_W-1:0] p_key;
        logic [TAG_BITS-1:0]     p_tag;
        logic                    p_less;
        logic signed [KEY_W-1:0] n_key;
        logic [TAG_BITS-1:0]     n_tag;
        logic                    n_less;

        if (i == 0) begin : g_first
            assign p_key  = s_fitness_key;
            assign p_tag  = tag_in;
            assign p_less = 1'b1;
        end else begin : g_mid
            assign p_key  = cell_key[i-1];
            assign p_tag  = cell_tag[i-1];
            assign p_less = cell_less[i-1];
        end

        if (i == MAX_ENTRIES - 1) begin : g_last
            assign n_key  = cell_key[i];
            assign n_tag  = cell_tag[i];
            assign n_less = 1'b0;
        end else begin : g_inner
            assign n_key  = cell_key[i+1];
            assign n_tag  = cell_tag[i+1];
            assign n_less = cell_less[i+1];
        end

        tk_cell #(
            .TAG_BITS (TAG_BITS),
            .CNT_W    (CNT_W),
            .INDEX    (i)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .new_tag   (tag_in),
            .count     (count_reg),
            .prev_key  (p_key),
            .prev_tag  (p_tag),
            .prev_less (p_less),
            .next_key  (n_key),
            .next_tag  (n_tag),
            .next_less (n_less),
            .key       (cell_key[i]),
            .tag       (cell_tag[i]),
            .less      (cell_less[i]),
            .key_next  (cell_key_next[i])
        );
    end

    assign count_next = (ctrl.insert && !ctrl.full) ? count_reg + CNT_W'(1) : count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Read port over the row
    assign rd_valid = IW'(s_read_index) < IW'(count_reg);
    always_comb begin
        rd_key = '0;
        rd_tag = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (IW'(s_read_index) == IW'(i)) begin
                rd_key = cell_key[i];
                rd_tag = cell_tag[i];
            end
        end
    end
    assign rd_tag_wide = TW'(rd_tag);

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            read_valid_reg  <= is_read && rd_valid;
            read_key_reg    <= (is_read && rd_valid) ? rd_key : '0;
            read_tag_reg    <= (is_read && rd_valid) ? rd_tag_wide[OUT_TAG_W-1:0] : '0;
            // refused when full and not above the minimum
            accepted_reg    <= !is_read && (!ctrl.full || cell_less[0]);
            minimum_key_reg <= (count_next == '0) ? '0 :
                               (ctrl.insert ? cell_key_next[0] : cell_key[0]);
            occupancy_reg   <= count_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_read_key    = read_key_reg;
    assign m_read_tag    = read_tag_reg;
    assign m_read_valid  = read_valid_reg;
    assign m_accepted    = accepted_reg;
    assign m_minimum_key = minimum_key_reg;
    assign m_occupancy   = occupancy_reg;

endmodule

FILE: bench/top_k_sorted_keeper_tb.sv
`timescale 1ns / 1ps

module top_k_sorted_keeper_tb;
    import tk_pkg::*;

    localparam int DEPTH      = 16;
    localparam int PHASE_LEN  = 95;
    localparam int LONG_HOLD  = 64;

    typedef struct packed {
        action_t                 act;
        logic signed [KEY_W-1:0] key;
        logic [OUT_TAG_W-1:0]    tag;
        logic [IDX_IN_W-1:0]     idx;
    } keeper_item_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] read_key;
        logic [OUT_TAG_W-1:0]    read_tag;
        logic                    read_valid;
        logic                    accepted;
        logic signed [KEY_W-1:0] minimum_key;
        logic [CAP_W-1:0]        occupancy;
    } keeper_result_t;

    typedef struct packed {
        logic             is_cfg;
        logic [CAP_W-1:0] cap;
        keeper_item_t     it;
        logic             typed;
        keeper_result_t   res;
    } stim_row_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_AW-1:0]       paddr;
    logic [APB_DW-1:0]       pwdata;
    logic [APB_DW-1:0]       prdata;
    logic                    pready;
    logic                    s_valid;
    logic                    s_ready;
    logic                    s_action;
    logic signed [KEY_W-1:0] s_fitness_key;
    logic [OUT_TAG_W-1:0]    s_entry_tag;
    logic [IDX_IN_W-1:0]     s_read_index;
    logic                    m_valid;
    logic                    m_ready;
    logic signed [KEY_W-1:0] m_read_key;
    logic [OUT_TAG_W-1:0]    m_read_tag;
    logic                    m_read_valid;
    logic                    m_accepted;
    logic signed [KEY_W-1:0] m_minimum_key;
    logic [CAP_W-1:0]        m_occupancy;

    top_k_sorted_keeper i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_fitness_key (s_fitness_key),
        .s_entry_tag   (s_entry_tag),
        .s_read_index  (s_read_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_key    (m_read_key),
        .m_read_tag    (m_read_tag),
        .m_read_valid  (m_read_valid),
        .m_accepted    (m_accepted),
        .m_minimum_key (m_minimum_key),
        .m_occupancy   (m_occupancy)
    );

    // shadow copy of the sorted list
    logic signed [KEY_W-1:0] kept_key [DEPTH];
    logic [OUT_TAG_W-1:0]    kept_tag [DEPTH];
    int unsigned             kept_count;
    logic signed [KEY_W-1:0] least_kept;
    logic [CAP_W-1:0]        cap_setting;

    keeper_result_t pending_results[$];
    stim_row_t      dir_rows[$];

    int  failures;
    int  results_checked;
    int  items_sent;
    int  n_stored;
    int  n_dropped;
    int  n_reads_hit;
    int  n_reads_miss;
    int  caps_written;
    int  in_stalls;
    int  burst_left;
    bit  long_hold_req;

    initial begin
        aclk = 1'b0;
    end

    always #4 aclk = ~aclk;

    function automatic keeper_result_t rank_entry(input keeper_item_t it);
        keeper_result_t r;
        int unsigned    pos;
        int unsigned    lim;
        int             i;
        r = '0;
        if (it.act == ACT_INSERT) begin
            lim = (cap_setting == 0) ? 1 : ((cap_setting > DEPTH) ? DEPTH : cap_setting);
            pos = 0;
            while (pos < kept_count && kept_key[pos] < it.key)
                pos++;
            if (kept_count < lim) begin
                for (i = kept_count; i > pos; i--) begin
                    kept_key[i] = kept_key[i-1];
                    kept_tag[i] = kept_tag[i-1];
                end
                kept_key[pos] = it.key;
                kept_tag[pos] = it.tag;
                kept_count++;
                r.accepted = 1'b1;
            end else if (pos != 0) begin
                // full: drop the smallest, slide lower entries down
                for (i = 0; i + 1 < pos; i++) begin
                    kept_key[i] = kept_key[i+1];
                    kept_tag[i] = kept_tag[i+1];
                end
                kept_key[pos-1] = it.key;
                kept_tag[pos-1] = it.tag;
                r.accepted = 1'b1;
            end
            if (r.accepted)
                least_kept = kept_key[0];
        end else if (it.idx < kept_count) begin
            r.read_key   = kept_key[it.idx];
            r.read_tag   = kept_tag[it.idx];
            r.read_valid = 1'b1;
        end
        r.minimum_key = (kept_count == 0) ? '0 : least_kept;
        r.occupancy   = CAP_W'(kept_count);
        return r;
    endfunction

    function automatic keeper_item_t random_item();
        keeper_item_t it;
        it.act = ($urandom_range(0, 9) < 7) ? ACT_INSERT : ACT_READ;
        it.tag = OUT_TAG_W'($urandom);
        it.idx = IDX_IN_W'($urandom_range(0, DEPTH - 1));
        case ($urandom_range(0, 3))
            0: begin
                it.key = $urandom;
            end
            1: begin
                // small set of keys, lots of ties
                it.key = ($signed($urandom_range(0, 6)) - 3) <<< 16;
            end
            2: begin
                it.key = least_kept + $signed($urandom_range(0, 4)) - 2;
            end
            default: begin
                it.key = $urandom_range(0, 32'h00FF_FFFF) + 32'h4000_0000;
            end
        endcase
        return it;
    endfunction

    function automatic void add_item(input action_t a, input logic signed [KEY_W-1:0] k,
                                     input logic [OUT_TAG_W-1:0] t,
                                     input logic [IDX_IN_W-1:0] i);
        stim_row_t r;
        r    = '0;
        r.it = '{act: a, key: k, tag: t, idx: i};
        dir_rows.push_back(r);
    endfunction

    function automatic void add_typed(input action_t a, input logic signed [KEY_W-1:0] k,
                                      input logic [OUT_TAG_W-1:0] t,
                                      input logic [IDX_IN_W-1:0] i,
                                      input logic signed [KEY_W-1:0] rk,
                                      input logic [OUT_TAG_W-1:0] rt, input logic rv,
                                      input logic ac, input logic signed [KEY_W-1:0] mk,
                                      input logic [CAP_W-1:0] oc);
        stim_row_t r;
        r       = '0;
        r.it    = '{act: a, key: k, tag: t, idx: i};
        r.typed = 1'b1;
        r.res   = '{read_key: rk, read_tag: rt, read_valid: rv, accepted: ac,
                    minimum_key: mk, occupancy: oc};
        dir_rows.push_back(r);
    endfunction

    function automatic void add_cfg(input logic [CAP_W-1:0] v);
        stim_row_t r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.cap    = v;
        dir_rows.push_back(r);
    endfunction

    task automatic check_result(input keeper_result_t exp, input keeper_result_t got);
        if (got.read_key !== exp.read_key) begin
            $error("read_key: expected %0d, got %0d", exp.read_key, got.read_key);
            failures++;
        end
        if (got.read_tag !== exp.read_tag) begin
            $error("read_tag: expected %0h, got %0h", exp.read_tag, got.read_tag);
            failures++;
        end
        if (got.read_valid !== exp.read_valid) begin
            $error("read_valid: expected %0b, got %0b", exp.read_valid, got.read_valid);
            failures++;
        end
        if (got.accepted !== exp.accepted) begin
            $error("accepted: expected %0b, got %0b", exp.accepted, got.accepted);
            failures++;
        end
        if (got.minimum_key !== exp.minimum_key) begin
            $error("minimum_key: expected %0d, got %0d", exp.minimum_key, got.minimum_key);
            failures++;
        end
        if (got.occupancy !== exp.occupancy) begin
            $error("occupancy: expected %0d, got %0d", exp.occupancy, got.occupancy);
            failures++;
        end
    endtask

    task automatic drive_item(input keeper_item_t it, input logic typed,
                              input keeper_result_t typed_res);
        keeper_result_t pred;
        s_valid       <= 1'b1;
        s_action      <= it.act;
        s_fitness_key <= it.key;
        s_entry_tag   <= it.tag;
        s_read_index  <= it.idx;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        pred = rank_entry(it);
        pending_results.push_back(typed ? typed_res : pred);
        items_sent++;
        if (it.act == ACT_INSERT) begin
            if (pred.accepted)
                n_stored++;
            else
                n_dropped++;
        end else if (pred.read_valid) begin
            n_reads_hit++;
        end else begin
            n_reads_miss++;
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = $urandom_range(0, 24);
        end
    endtask

    // drain everything in flight; the block is idle after that
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_CAPACITY, 2'b00};
        pwdata  <= APB_DW'(val);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        cap_setting  = val;
        caps_written++;
    endtask

    always @(posedge aclk) begin : result_check
        keeper_result_t got;
        keeper_result_t exp;
        if (aresetn && m_valid && m_ready) begin
            got = '{read_key: m_read_key, read_tag: m_read_tag, read_valid: m_read_valid,
                    accepted: m_accepted, minimum_key: m_minimum_key,
                    occupancy: m_occupancy};
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected");
                failures++;
            end else begin
                exp = pending_results.pop_front();
                check_result(exp, got);
                results_checked++;
            end
        end
        if (aresetn && s_valid && !s_ready)
            in_stalls++;
    end

    // receiver: stretches of differing ready patterns, one long hold on request
    initial begin : receiver
        int mode;
        int len;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if (long_hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold_req = 1'b0;
            end else begin
                mode = $urandom_range(0, 3);
                len  = $urandom_range(4, 40);
                repeat (len) begin
                    case (mode)
                        0: m_ready <= 1'b1;
                        1: m_ready <= 1'($urandom_range(0, 1));
                        2: m_ready <= ($urandom_range(0, 3) == 0);
                        default: m_ready <= ~m_ready;
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        logic [CAP_W-1:0] cap_plan [10];
        int               waited;
        cap_plan = '{5'd3, 5'd16, 5'd0, 5'd9, 5'd31, 5'd1, 5'd16, 5'd5, 5'd12, 5'd16};

        aresetn       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_valid       = 1'b0;
        s_action      = 1'b0;
        s_fitness_key = '0;
        s_entry_tag   = '0;
        s_read_index  = '0;
        failures      = 0;
        kept_count    = 0;
        least_kept    = '0;
        cap_setting   = CAP_RESET;
        burst_left    = 0;
        long_hold_req = 1'b0;
        foreach (kept_key[n]) begin
            kept_key[n] = '0;
            kept_tag[n] = '0;
        end

        // empty list, then capacity zero acting as one
        add_typed(ACT_READ,   32'sd0,          16'h0000, 4'd0,
                  32'sd0, 16'h0, 1'b0, 1'b0, 32'sd0, 5'd0);
        add_cfg(5'd0);
        add_typed(ACT_INSERT, 32'sh0001_0000, 16'h0001, 4'd0,
                  32'sd0, 16'h0, 1'b0, 1'b1, 32'sh0001_0000, 5'd1);
        add_typed(ACT_INSERT, 32'sh0000_8000, 16'h0002, 4'd0,
                  32'sd0, 16'h0, 1'b0, 1'b0, 32'sh0001_0000, 5'd1);
        // key equal to the minimum on a full list is refused
        add_typed(ACT_INSERT, 32'sh0001_0000, 16'h0003, 4'd0,
                  32'sd0, 16'h0, 1'b0, 1'b0, 32'sh0001_0000, 5'd1);
        add_typed(ACT_INSERT, 32'sh7FFF_FFFF, 16'hFFFF, 4'd0,
                  32'sd0, 16'h0, 1'b0, 1'b1, 32'sh7FFF_FFFF, 5'd1);
        // capacity above the list size saturates
        add_cfg(5'd31);
        add_typed(ACT_INSERT, 32'sh8000_0000, 16'h0000, 4'd15,
                  32'sd0, 16'h0, 1'b0, 1'b1, 32'sh8000_0000, 5'd2);
        add_typed(ACT_READ,   32'sd0,          16'h0000, 4'd0,
                  32'sh8000_0000, 16'h0000, 1'b1, 1'b0, 32'sh8000_0000, 5'd2);
        add_typed(ACT_READ,   32'sh7FFF_FFFF, 16'hFFFF, 4'd1,
                  32'sh7FFF_FFFF, 16'hFFFF, 1'b1, 1'b0, 32'sh8000_0000, 5'd2);
        add_typed(ACT_READ,   32'sd0,          16'h0000, 4'd15,
                  32'sd0, 16'h0, 1'b0, 1'b0, 32'sh8000_0000, 5'd2);
        // equal keys: the newer one lands in front
        add_item(ACT_INSERT, 32'sd0,          16'h5555, 4'd0);
        add_item(ACT_INSERT, 32'sd0,          16'hAAAA, 4'd0);
        add_item(ACT_READ,   32'sd0,          16'h0000, 4'd1);
        add_item(ACT_READ,   32'sd0,          16'h0000, 4'd2);
        add_item(ACT_INSERT, -32'sd1,         16'h1234, 4'd7);
        // shrink below occupancy: list counts as full, entries stay
        add_cfg(5'd4);
        add_item(ACT_INSERT, 32'sh8000_0000, 16'h0007, 4'd0);
        add_item(ACT_INSERT, 32'sd1,          16'h0008, 4'd0);
        add_item(ACT_READ,   32'sd0,          16'h0000, 4'd4);
        add_item(ACT_READ,   32'sd0,          16'h0000, 4'd5);
        add_cfg(5'd16);
        add_item(ACT_INSERT, 32'sh4000_0000, 16'h0009, 4'd0);
        add_item(ACT_READ,   32'sd0,          16'h0000, 4'd0);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[n]) begin
            if (dir_rows[n].is_cfg) begin
                settle();
                write_capacity(dir_rows[n].cap);
            end else begin
                drive_item(dir_rows[n].it, dir_rows[n].typed, dir_rows[n].res);
            end
        end

        foreach (cap_plan[p]) begin
            settle();
            write_capacity(cap_plan[p]);
            if (p == 2)
                long_hold_req = 1'b1;
            repeat (PHASE_LEN) drive_item(random_item(), 1'b0, '0);
        end

        s_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (5) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            failures++;
        end

        $display("%0d transfers in, %0d results checked, %0d capacity writes, %0d stall cycles",
                 items_sent, results_checked, caps_written, in_stalls);
        $display("inserts kept %0d, refused %0d; reads in range %0d, past occupancy %0d",
                 n_stored, n_dropped, n_reads_hit, n_reads_miss);
        if (failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
